/* hw/rtl/console_command_line_parser_unit_macros.svh */
// Assertion helpers for the console command line parser.
`ifndef CONSOLE_COMMAND_LINE_PARSER_UNIT_MACROS_SVH
`define CONSOLE_COMMAND_LINE_PARSER_UNIT_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define CCL_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ccl check failed");

// next-cycle implication
`define CCL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ccl check failed");

`endif

/* hw/rtl/ccl_pkg.sv */
`default_nettype none
package ccl_pkg;

    localparam int LINE_MAX = 32;
    localparam int LEN_W    = $clog2(LINE_MAX + 1);
    localparam int ADDR_W   = $clog2(LINE_MAX);
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(LINE_MAX);

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_S     = "S";
    localparam logic [7:0] CH_T     = "T";
    localparam logic [7:0] CH_ONE   = "1";
    localparam logic [7:0] CH_TWO   = "2";
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NINE  = "9";

    localparam logic [19:0] NUM_LIMIT = 20'h0FFFF;

    // keyword table, matched after the optional station prefix
    localparam int NUM_KW = 5;
    localparam logic [2:0] KW_THR_Q   = 3'd0;
    localparam logic [2:0] KW_STATUS  = 3'd1;
    localparam logic [2:0] KW_HELP    = 3'd2;
    localparam logic [2:0] KW_SERVO   = 3'd3;
    localparam logic [2:0] KW_THR_SET = 3'd4;

    localparam logic [2:0] KW_LEN [0:NUM_KW-1] = '{3'd4, 3'd7, 3'd4, 3'd6, 3'd4};

    localparam logic [7:0] KW_TEXT [0:NUM_KW-1][0:7] = '{
        '{"T", "H", "R", "?", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"S", "T", "A", "T", "U", "S", "?", 8'h00},
        '{"H", "E", "L", "P", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"S", "E", "R", "V", "O", "=", 8'h00, 8'h00},
        '{"T", "H", "R", "=", 8'h00, 8'h00, 8'h00, 8'h00}
    };

    typedef enum logic [3:0] {
        CODE_THR_QUERY    = 4'd0,
        CODE_STATUS_QUERY = 4'd1,
        CODE_HELP         = 4'd2,
        CODE_SERVO_WRITE  = 4'd3,
        CODE_THR_WRITE    = 4'd4,
        CODE_BAD_NUMBER   = 4'd5,
        CODE_ANGLE_RANGE  = 4'd6,
        CODE_THR_RANGE    = 4'd7,
        CODE_UNKNOWN      = 4'd8
    } t_code;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_THR_MIN   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THR_MAX   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO_MIN = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO_MAX = 8'd3;

    localparam logic [15:0] RST_THR_MIN   = 16'd0;
    localparam logic [15:0] RST_THR_MAX   = 16'd3300;
    localparam logic [15:0] RST_SERVO_MIN = 16'd0;
    localparam logic [15:0] RST_SERVO_MAX = 16'd180;

    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] len;
    } t_scan_req;

    typedef struct packed {
        logic [15:0] thr_min;
        logic [15:0] thr_max;
        logic [15:0] servo_min;
        logic [15:0] servo_max;
    } t_cfg_lim;

endpackage
`default_nettype wire

/* hw/rtl/ccl_linebuf.sv */
`default_nettype none
module ccl_linebuf (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_byte_we,
    input  wire logic [7:0]                i_byte,
    input  wire logic [ccl_pkg::ADDR_W-1:0] i_rd_addr,
    output logic      [7:0]                o_rd_data,
    output ccl_pkg::t_scan_req             o_req
);
    import ccl_pkg::*;

    logic [7:0]       r_mem [0:LINE_MAX-1];
    logic [7:0]       r_rd_data;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;
    logic             wr_en;
    logic             is_term;
    logic             is_del;
    logic             is_print;

    assign is_term  = (i_byte == CH_CR) || (i_byte == CH_LF);
    assign is_del   = (i_byte == CH_BS) || (i_byte == CH_DEL);
    assign is_print = (i_byte >= CH_SP) && (i_byte <= CH_TILDE);

    always_comb begin
        n_len       = r_len;
        wr_en       = 1'b0;
        o_req.start = 1'b0;
        o_req.len   = r_len;
        if (i_byte_we) begin
            if (is_term) begin
                if (r_len != '0) begin
                    o_req.start = 1'b1;
                    n_len       = '0;
                end
            end else if (is_del) begin
                if (r_len != '0) begin
                    n_len = r_len - LEN_W'(1);
                end
            end else if (is_print) begin
                // printable byte on a full line wipes the line
                if (r_len == LEN_FULL) begin
                    n_len = '0;
                end else begin
                    wr_en = 1'b1;
                    n_len = r_len + LEN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else begin
            r_len <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_len[ADDR_W-1:0]] <= i_byte;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

/* hw/rtl/ccl_scan.sv */
`default_nettype none
module ccl_scan (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire ccl_pkg::t_scan_req         i_req,
    input  wire logic [7:0]                 i_rd_data,
    output logic      [ccl_pkg::ADDR_W-1:0] o_rd_addr,
    input  wire ccl_pkg::t_cfg_lim          i_lim,
    output logic                            o_busy,
    output logic                            o_res_valid,
    output ccl_pkg::t_code                  o_result_code,
    output logic      [15:0]                o_value,
    input  wire logic                       i_take
);
    import ccl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PFX,
        S_SCAN,
        S_FIN,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [LEN_W-1:0]   r_len;
    logic [LEN_W-1:0]   r_iss;
    logic [LEN_W-1:0]   r_j;
    logic               r_vld;
    logic               r_pfx_ok;
    logic               r_s3;
    logic [NUM_KW-1:0]  r_flags;
    logic               r_tword;
    logic [15:0]        r_acc;
    logic               r_bad;
    logic               r_ndig;
    t_code              r_code;
    logic [15:0]        r_val;

    logic [7:0]         ch;
    logic               pfx_hit;
    logic [NUM_KW-1:0]  n_flags;
    logic               is_digit;
    logic [19:0]        acc_ext;
    logic [19:0]        mac_sum;
    logic [LEN_W-1:0]   dstart;
    logic               in_num;
    logic [LEN_W-1:0]   rel_len;
    logic [15:0]        lo_lim;
    logic [15:0]        hi_lim;
    logic               out_rng;
    t_code              fin_code;
    logic [15:0]        fin_val;

    assign ch = i_rd_data;

    always_comb begin
        case (r_j)
            LEN_W'(0): pfx_hit = (ch == CH_S);
            LEN_W'(1): pfx_hit = (ch == CH_ONE) || (ch == CH_TWO);
            default:   pfx_hit = (ch == CH_SP);
        endcase
    end

    // per-keyword running match; each keyword is independent
    always_comb begin
        n_flags = r_flags;
        for (int k = 0; k < NUM_KW; k++) begin
            if ((r_j < LEN_W'(KW_LEN[k])) && (ch != KW_TEXT[k][r_j[2:0]])) begin
                n_flags[k] = 1'b0;
            end
        end
    end

    // shared multiply-by-ten and add unit
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign acc_ext  = {4'b0000, r_acc};
    assign mac_sum  = (acc_ext << 3) + (acc_ext << 1) + {16'h0000, ch[3:0]};
    assign dstart   = r_tword ? LEN_W'(4) : LEN_W'(6);
    assign in_num   = (r_j >= dstart);
    assign rel_len  = r_len - (r_s3 ? LEN_W'(3) : LEN_W'(0));

    assign lo_lim  = r_flags[KW_SERVO] ? i_lim.servo_min : i_lim.thr_min;
    assign hi_lim  = r_flags[KW_SERVO] ? i_lim.servo_max : i_lim.thr_max;
    assign out_rng = (r_acc < lo_lim) || (r_acc > hi_lim);

    always_comb begin
        fin_code = CODE_UNKNOWN;
        fin_val  = 16'h0000;
        if (r_flags[KW_THR_Q] && (rel_len == LEN_W'(4))) begin
            fin_code = CODE_THR_QUERY;
        end else if (r_flags[KW_STATUS] && (rel_len == LEN_W'(7))) begin
            fin_code = CODE_STATUS_QUERY;
        end else if (r_flags[KW_HELP] && (rel_len == LEN_W'(4))) begin
            fin_code = CODE_HELP;
        end else if (r_flags[KW_SERVO] && (rel_len >= LEN_W'(6))) begin
            if (r_bad || !r_ndig) begin
                fin_code = CODE_BAD_NUMBER;
            end else begin
                fin_val  = r_acc;
                fin_code = out_rng ? CODE_ANGLE_RANGE : CODE_SERVO_WRITE;
            end
        end else if (r_flags[KW_THR_SET] && (rel_len >= LEN_W'(4))) begin
            if (r_bad || !r_ndig) begin
                fin_code = CODE_BAD_NUMBER;
            end else begin
                fin_val  = r_acc;
                fin_code = out_rng ? CODE_THR_RANGE : CODE_THR_WRITE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_len    <= i_req.len;
                        r_iss    <= '0;
                        r_j      <= '0;
                        r_vld    <= 1'b0;
                        r_pfx_ok <= 1'b1;
                        r_s3     <= 1'b0;
                        r_flags  <= '1;
                        r_tword  <= 1'b0;
                        r_acc    <= 16'h0000;
                        r_bad    <= 1'b0;
                        r_ndig   <= 1'b0;
                        r_state  <= (i_req.len >= LEN_W'(3)) ? S_PFX : S_SCAN;
                    end
                end
                S_PFX: begin
                    if (r_iss < LEN_W'(3)) begin
                        r_iss <= r_iss + LEN_W'(1);
                        r_vld <= 1'b1;
                    end else begin
                        r_vld <= 1'b0;
                    end
                    if (r_vld) begin
                        if (r_j == LEN_W'(2)) begin
                            // prefix decided: restart the read pointer past it or at 0
                            r_s3    <= r_pfx_ok && pfx_hit;
                            r_iss   <= (r_pfx_ok && pfx_hit) ? LEN_W'(3) : LEN_W'(0);
                            r_j     <= '0;
                            r_state <= S_SCAN;
                        end else begin
                            r_pfx_ok <= r_pfx_ok && pfx_hit;
                            r_j      <= r_j + LEN_W'(1);
                        end
                    end
                end
                S_SCAN: begin
                    if (r_iss < r_len) begin
                        r_iss <= r_iss + LEN_W'(1);
                        r_vld <= 1'b1;
                    end else begin
                        r_vld <= 1'b0;
                    end
                    if (r_vld) begin
                        r_flags <= n_flags;
                        r_j     <= r_j + LEN_W'(1);
                        if (r_j == '0) begin
                            r_tword <= (ch == CH_T);
                        end
                        if (in_num && !r_bad) begin
                            if (is_digit) begin
                                r_ndig <= 1'b1;
                                if (mac_sum > NUM_LIMIT) begin
                                    r_bad <= 1'b1;
                                end else begin
                                    r_acc <= mac_sum[15:0];
                                end
                            end else begin
                                r_bad <= 1'b1;
                            end
                        end
                    end else if (r_iss >= r_len) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_code  <= fin_code;
                    r_val   <= fin_val;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rd_addr     = r_iss[ADDR_W-1:0];
    assign o_busy        = (r_state != S_IDLE);
    assign o_res_valid   = (r_state == S_DONE);
    assign o_result_code = r_code;
    assign o_value       = r_val;

endmodule
`default_nettype wire

/* hw/rtl/console_command_line_parser_unit.sv */
// Channel  Direction  Handshake                  Payload
// rx       in         i_rx_valid / o_rx_ready    i_rx_byte[7:0]
// res      out        o_res_valid / i_res_ready  o_result_code[3:0], o_value[15:0]
// cfg      in         i_cfg_valid / o_cfg_ready  i_cfg_index[7:0], i_cfg_data[15:0]
//
// Editing bytes are taken while no scan runs. A CR or LF on a non-empty line
// starts a scan, one character per cycle through the buffer's registered read
// port, after a station prefix check on lines of three or more characters;
// rx ready stays low until the result moves to the output register.
// A finished scan moves to the output register once it is free; bytes of the
// next line are taken while a result waits there. Sync active-low reset.
`default_nettype none
module console_command_line_parser_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_rx_valid,
    output logic                               o_rx_ready,
    input  wire logic [7:0]                    i_rx_byte,
    output logic                               o_res_valid,
    input  wire logic                          i_res_ready,
    output logic      [3:0]                    o_result_code,
    output logic      [15:0]                   o_value,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [ccl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]                   i_cfg_data
);
    import ccl_pkg::*;

    t_cfg_lim          r_lim;
    logic              r_out_valid;
    logic [3:0]        r_out_code;
    logic [15:0]       r_out_val;

    logic              rx_acc;
    logic              cfg_acc;
    t_scan_req         req;
    logic [7:0]        rd_data;
    logic [ADDR_W-1:0] rd_addr;
    logic              scan_busy;
    logic              scan_valid;
    t_code             scan_code;
    logic [15:0]       scan_val;
    logic              take;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign o_rx_ready  = !scan_busy;
    assign rx_acc      = i_rx_valid && o_rx_ready;
    assign take        = scan_valid && (!r_out_valid || i_res_ready);

    ccl_linebuf u_linebuf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_we (rx_acc),
        .i_byte    (i_rx_byte),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .o_req     (req)
    );

    ccl_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req),
        .i_rd_data     (rd_data),
        .o_rd_addr     (rd_addr),
        .i_lim         (r_lim),
        .o_busy        (scan_busy),
        .o_res_valid   (scan_valid),
        .o_result_code (scan_code),
        .o_value       (scan_val),
        .i_take        (take)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim.thr_min   <= RST_THR_MIN;
            r_lim.thr_max   <= RST_THR_MAX;
            r_lim.servo_min <= RST_SERVO_MIN;
            r_lim.servo_max <= RST_SERVO_MAX;
        end else if (cfg_acc) begin
            case (i_cfg_index)
                REG_THR_MIN:   r_lim.thr_min   <= i_cfg_data;
                REG_THR_MAX:   r_lim.thr_max   <= i_cfg_data;
                REG_SERVO_MIN: r_lim.servo_min <= i_cfg_data;
                REG_SERVO_MAX: r_lim.servo_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
            r_out_code  <= scan_code;
            r_out_val   <= scan_val;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res_valid   = r_out_valid;
    assign o_result_code = r_out_code;
    assign o_value       = r_out_val;

endmodule
`default_nettype wire

/* hw/rtl/ccl_checker.sv */
`default_nettype none
`include "console_command_line_parser_unit_macros.svh"
module ccl_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_rx_valid,
    input  wire logic                          o_rx_ready,
    input  wire logic [7:0]                    i_rx_byte,
    input  wire logic                          o_res_valid,
    input  wire logic                          i_res_ready,
    input  wire logic [3:0]                    o_result_code,
    input  wire logic [15:0]                   o_value,
    input  wire logic                          i_cfg_valid,
    input  wire logic                          o_cfg_ready,
    input  wire logic [ccl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]                   i_cfg_data
);
    import ccl_pkg::*;

    logic rx_acc;
    logic not_term;
    logic no_val_code;
    logic cfg_seen;

    assign rx_acc   = i_rx_valid && o_rx_ready;
    assign not_term = (i_rx_byte != CH_CR) && (i_rx_byte != CH_LF);
    assign no_val_code = (o_result_code == CODE_THR_QUERY)
                      || (o_result_code == CODE_STATUS_QUERY)
                      || (o_result_code == CODE_HELP)
                      || (o_result_code == CODE_BAD_NUMBER)
                      || (o_result_code == CODE_UNKNOWN);
    assign cfg_seen = i_cfg_valid;

    // only a line terminator can start a scan and drop rx ready
    `CCL_ASSERT_NEXT(a_edit_keeps_ready, rx_acc && not_term, o_rx_ready)
    `CCL_ASSERT_SAME(a_code_known, o_res_valid, o_result_code <= CODE_UNKNOWN)
    `CCL_ASSERT_SAME(a_value_zero, o_res_valid && no_val_code, o_value == 16'h0000)
    `CCL_ASSERT_NEXT(a_res_hold, o_res_valid && !i_res_ready,
                     o_res_valid && $stable(o_result_code) && $stable(o_value))
    `CCL_ASSERT_SAME(a_cfg_always_ready, cfg_seen, o_cfg_ready)

endmodule

bind console_command_line_parser_unit ccl_checker u_ccl_checker (.*);
`default_nettype wire
